[rtl/core/mcmq_pkg.sv]
package mcmq_pkg;

	localparam int CHANNELS    = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int BODY_BYTES  = 8;
	localparam int CH_W        = 4;
	localparam int QP_W        = 4;
	localparam int FILL_W      = 5;
	localparam int ADDR_W      = CH_W + QP_W;

	localparam logic [2:0] K_CREATE   = 3'd0;
	localparam logic [2:0] K_SEND     = 3'd1;
	localparam logic [2:0] K_RECV     = 3'd2;
	localparam logic [2:0] K_DESTROY  = 3'd3;
	localparam logic [2:0] K_SEND_OWN = 3'd4;
	localparam logic [2:0] K_RECV_OWN = 3'd5;

	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_BAD_SIZE     = 4'd1;
	localparam logic [3:0] ST_NOT_OPEN     = 4'd2;
	localparam logic [3:0] ST_FULL         = 4'd3;
	localparam logic [3:0] ST_EMPTY        = 4'd4;
	localparam logic [3:0] ST_SRC_MISMATCH = 4'd5;
	localparam logic [3:0] ST_NO_SLOT      = 4'd6;
	localparam logic [3:0] ST_NOT_CREATOR  = 4'd7;
	localparam logic [3:0] ST_NO_ROUTE     = 4'd8;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic decide;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic unused_flag;
	} stat_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++)
			if (4'(b) < n) m[8*b +: 8] = 8'hFF;
		return m;
	endfunction

endpackage

[rtl/core/mcmq_ctrl.sv]
module mcmq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output mcmq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_DECIDE = 2'b10
	} state_t;

	state_t state_q;

	// advance: capture request, then decide and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (start) state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q == S_DECIDE);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.decide  = (state_q == S_DECIDE);

endmodule

[rtl/core/mcmq_dp.sv]
module mcmq_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  mcmq_pkg::cmd_t cmd,
	input  logic [2:0]     kind,
	input  logic [15:0]    requester_id,
	input  logic [3:0]     channel_index,
	input  logic [15:0]    peer_id,
	input  logic [31:0]    msg_type,
	input  logic [3:0]     msg_bytes,
	input  logic [63:0]    payload,
	input  logic [3:0]     size_limit,
	input  logic [7:0]     depth_limit,
	output logic           done,
	output logic [3:0]     status,
	output logic [3:0]     slot,
	output logic [31:0]    got_type,
	output logic [3:0]     got_bytes,
	output logic [63:0]    got_payload,
	output logic [15:0]    got_sender
);

	localparam int CH = mcmq_pkg::CHANNELS;
	localparam int AW = mcmq_pkg::ADDR_W;

	// channel table
	logic [CH-1:0]                    live_q;
	logic [CH-1:0][15:0]              owner_q, creator_q;
	logic [CH-1:0][3:0]               size_cap_q;
	logic [CH-1:0][mcmq_pkg::FILL_W-1:0] depth_cap_q, fill_q;
	logic [CH-1:0][mcmq_pkg::QP_W-1:0]   head_q, tail_q;

	// message store
	logic [15:0] mem_sender [2**AW];
	logic [31:0] mem_type   [2**AW];
	logic [3:0]  mem_bytes  [2**AW];
	logic [63:0] mem_body   [2**AW];

	// captured request
	logic [2:0]  kind_q;
	logic [15:0] req_q, peer_q;
	logic [31:0] mtype_q;
	logic [3:0]  mbytes_q, slim_q;
	logic [63:0] body_q;
	logic [7:0]  dlim_q;
	logic [3:0]  ch_q;
	logic        found_q;
	logic [15:0] rd_sender_q;
	logic [31:0] rd_type_q;
	logic [3:0]  rd_bytes_q;
	logic [63:0] rd_body_q;

	// channel select: lowest free or lowest owned by key
	logic [15:0] key;
	logic        found;
	logic [3:0]  ch_sel;
	always_comb begin
		key    = (kind == mcmq_pkg::K_SEND_OWN) ? peer_id : requester_id;
		found  = 1'b0;
		ch_sel = channel_index;
		if (kind == mcmq_pkg::K_CREATE || kind == mcmq_pkg::K_SEND_OWN ||
		    kind == mcmq_pkg::K_RECV_OWN) begin
			ch_sel = '0;
			for (int i = CH-1; i >= 0; i--) begin
				if (kind == mcmq_pkg::K_CREATE ? !live_q[i]
				    : (live_q[i] && owner_q[i] == key)) begin
					found  = 1'b1;
					ch_sel = 4'(i);
				end
			end
		end else begin
			found = 1'b1;
		end
	end

	// capture request and read head entry
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			req_q    <= requester_id;
			peer_q   <= peer_id;
			mtype_q  <= msg_type;
			mbytes_q <= msg_bytes;
			body_q   <= payload;
			slim_q   <= size_limit;
			dlim_q   <= depth_limit;
			ch_q     <= ch_sel;
			found_q  <= found;
			rd_sender_q <= mem_sender[{ch_sel, head_q[ch_sel]}];
			rd_type_q   <= mem_type[{ch_sel, head_q[ch_sel]}];
			rd_bytes_q  <= mem_bytes[{ch_sel, head_q[ch_sel]}];
			rd_body_q   <= mem_body[{ch_sel, head_q[ch_sel]}];
		end
	end

	// decide
	logic [3:0]  st;
	logic        do_push, do_pop, do_create, do_destroy;
	logic [3:0]  wbytes;
	logic        lv;
	logic [4:0]  fl;
	always_comb begin
		st = mcmq_pkg::ST_OK;
		do_push = 1'b0; do_pop = 1'b0; do_create = 1'b0; do_destroy = 1'b0;
		lv = live_q[ch_q];
		fl = fill_q[ch_q];
		wbytes = mbytes_q;
		unique case (kind_q)
			mcmq_pkg::K_CREATE: begin
				if (!found_q) st = mcmq_pkg::ST_NO_SLOT;
				else do_create = 1'b1;
			end
			mcmq_pkg::K_SEND: begin
				if (mbytes_q > 4'(mcmq_pkg::BODY_BYTES)) st = mcmq_pkg::ST_BAD_SIZE;
				else if (!lv) st = mcmq_pkg::ST_NOT_OPEN;
				else if (fl >= depth_cap_q[ch_q] || fl >= 5'(mcmq_pkg::QUEUE_DEPTH))
					st = mcmq_pkg::ST_FULL;
				else begin
					do_push = 1'b1;
					if (mbytes_q > size_cap_q[ch_q]) wbytes = size_cap_q[ch_q];
				end
			end
			mcmq_pkg::K_RECV: begin
				if (!lv) st = mcmq_pkg::ST_NOT_OPEN;
				else if (fl == '0) st = mcmq_pkg::ST_EMPTY;
				else do_pop = 1'b1;
			end
			mcmq_pkg::K_DESTROY: begin
				if (creator_q[ch_q] != req_q) st = mcmq_pkg::ST_NOT_CREATOR;
				else do_destroy = 1'b1;
			end
			mcmq_pkg::K_SEND_OWN: begin
				if (mbytes_q > 4'(mcmq_pkg::BODY_BYTES)) st = mcmq_pkg::ST_BAD_SIZE;
				else if (!found_q) st = mcmq_pkg::ST_NO_ROUTE;
				else if (fl >= 5'(mcmq_pkg::QUEUE_DEPTH)) st = mcmq_pkg::ST_FULL;
				else do_push = 1'b1;
			end
			mcmq_pkg::K_RECV_OWN: begin
				if (!found_q) st = mcmq_pkg::ST_NO_ROUTE;
				else if (fl == '0) st = mcmq_pkg::ST_EMPTY;
				else if (peer_q != '0 && rd_sender_q != peer_q)
					st = mcmq_pkg::ST_SRC_MISMATCH;
				else do_pop = 1'b1;
			end
			default: st = mcmq_pkg::ST_NO_ROUTE;
		endcase
	end

	// store write
	always_ff @(posedge clk) begin
		if (cmd.decide && do_push) begin
			mem_sender[{ch_q, tail_q[ch_q]}] <= req_q;
			mem_type[{ch_q, tail_q[ch_q]}]   <= mtype_q;
			mem_bytes[{ch_q, tail_q[ch_q]}]  <= wbytes;
			mem_body[{ch_q, tail_q[ch_q]}]   <= body_q & mcmq_pkg::byte_mask(wbytes);
		end
	end

	// table update and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0; owner_q <= '0; creator_q <= '0; size_cap_q <= '0;
			depth_cap_q <= '0; fill_q <= '0; head_q <= '0; tail_q <= '0;
			done <= 1'b0;
			status <= '0; slot <= '0; got_type <= '0; got_bytes <= '0;
			got_payload <= '0; got_sender <= '0;
		end else begin
			done <= cmd.decide;
			if (cmd.decide) begin
				status      <= st;
				slot        <= do_create ? ch_q : '0;
				got_type    <= do_pop ? rd_type_q : '0;
				got_bytes   <= do_pop ? rd_bytes_q : '0;
				got_payload <= do_pop ? rd_body_q : '0;
				got_sender  <= do_pop ? rd_sender_q : '0;
				if (do_create) begin
					live_q[ch_q]      <= 1'b1;
					owner_q[ch_q]     <= req_q;
					creator_q[ch_q]   <= req_q;
					size_cap_q[ch_q]  <= (slim_q == '0 || slim_q > 4'(mcmq_pkg::BODY_BYTES))
						? 4'(mcmq_pkg::BODY_BYTES) : slim_q;
					depth_cap_q[ch_q] <= (dlim_q == '0 || dlim_q > 8'(mcmq_pkg::QUEUE_DEPTH))
						? 5'(mcmq_pkg::QUEUE_DEPTH) : dlim_q[4:0];
					head_q[ch_q] <= '0; tail_q[ch_q] <= '0; fill_q[ch_q] <= '0;
				end
				if (do_destroy) begin
					live_q[ch_q] <= 1'b0;
					head_q[ch_q] <= '0; tail_q[ch_q] <= '0; fill_q[ch_q] <= '0;
				end
				if (do_push) begin
					tail_q[ch_q] <= tail_q[ch_q] + 1'b1;
					fill_q[ch_q] <= fill_q[ch_q] + 1'b1;
				end
				if (do_pop) begin
					head_q[ch_q] <= head_q[ch_q] + 1'b1;
					fill_q[ch_q] <= fill_q[ch_q] - 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/multi_channel_mailbox_queue_core.sv]
// channel  | signals                                  | transfer
// request  | start, busy, kind .. depth_limit         | start && !busy
// result   | done, status, slot, got_*                | done (one cycle)
// Each request is captured with the head-entry read of the message store,
// then checked and committed to the channel table and store.
// done pulses in the cycle in which busy falls; a new start is taken that cycle.
// Reset clears the channel table; the message store needs no clearing.
// The result side has no backpressure.
module multi_channel_mailbox_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [15:0] requester_id,
	input  logic [3:0]  channel_index,
	input  logic [15:0] peer_id,
	input  logic [31:0] msg_type,
	input  logic [3:0]  msg_bytes,
	input  logic [63:0] payload,
	input  logic [3:0]  size_limit,
	input  logic [7:0]  depth_limit,
	output logic        done,
	output logic [3:0]  status,
	output logic [3:0]  slot,
	output logic [31:0] got_type,
	output logic [3:0]  got_bytes,
	output logic [63:0] got_payload,
	output logic [15:0] got_sender
);

	mcmq_pkg::cmd_t cmd;

	mcmq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd)
	);

	mcmq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.kind(kind), .requester_id(requester_id), .channel_index(channel_index),
		.peer_id(peer_id), .msg_type(msg_type), .msg_bytes(msg_bytes),
		.payload(payload), .size_limit(size_limit), .depth_limit(depth_limit),
		.done(done), .status(status), .slot(slot), .got_type(got_type),
		.got_bytes(got_bytes), .got_payload(got_payload), .got_sender(got_sender)
	);

endmodule

[tb/mailbox_result_checker.sv]
module mailbox_result_checker
	import mcmq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [15:0] requester_id,
	input  logic [3:0]  channel_index,
	input  logic [15:0] peer_id,
	input  logic [31:0] msg_type,
	input  logic [3:0]  msg_bytes,
	input  logic [63:0] payload,
	input  logic [3:0]  size_limit,
	input  logic [7:0]  depth_limit,
	input  logic        done,
	input  logic [3:0]  status,
	input  logic [3:0]  slot,
	input  logic [31:0] got_type,
	input  logic [3:0]  got_bytes,
	input  logic [63:0] got_payload,
	input  logic [15:0] got_sender,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  slot;
		logic [31:0] rtype;
		logic [3:0]  rbytes;
		logic [63:0] rbody;
		logic [15:0] rsender;
	} reply_t;

	// predicted channel table and message store
	logic        live    [CHANNELS];
	logic [15:0] owner   [CHANNELS];
	logic [15:0] creator [CHANNELS];
	logic [3:0]  size_cap[CHANNELS];
	logic [4:0]  depth_cap[CHANNELS];
	logic [3:0]  head    [CHANNELS];
	logic [3:0]  tail    [CHANNELS];
	logic [4:0]  fill    [CHANNELS];
	logic [15:0] m_sender[CHANNELS*QUEUE_DEPTH];
	logic [31:0] m_type  [CHANNELS*QUEUE_DEPTH];
	logic [3:0]  m_bytes [CHANNELS*QUEUE_DEPTH];
	logic [63:0] m_body  [CHANNELS*QUEUE_DEPTH];

	reply_t expected_replies[$];

	function automatic logic [63:0] keep_bytes(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++)
			if (b < n) m[8*b +: 8] = 8'hFF;
		return m;
	endfunction

	function automatic int find_owned(input logic [15:0] id);
		for (int i = 0; i < CHANNELS; i++)
			if (live[i] && owner[i] == id) return i;
		return -1;
	endfunction

	task automatic enqueue_msg(input int ch, input logic [15:0] snd, input logic [31:0] t,
			input logic [3:0] n, input logic [63:0] b);
		int pos;
		pos = ch * QUEUE_DEPTH + head[ch] * 0 + tail[ch];
		m_sender[pos] = snd;
		m_type[pos]   = t;
		m_bytes[pos]  = n;
		m_body[pos]   = b & keep_bytes(n);
		tail[ch]      = tail[ch] + 4'd1;
		fill[ch]      = fill[ch] + 5'd1;
	endtask

	task automatic dequeue_msg(input int ch, inout reply_t r);
		int pos;
		pos = ch * QUEUE_DEPTH + head[ch];
		r.rtype   = m_type[pos];
		r.rbytes  = m_bytes[pos];
		r.rbody   = m_body[pos];
		r.rsender = m_sender[pos];
		head[ch]  = head[ch] + 4'd1;
		fill[ch]  = fill[ch] - 5'd1;
	endtask

	// compute the reply of one request and advance the mailbox state
	task automatic predict_mailbox_reply();
		reply_t r;
		int ch;
		logic [3:0] n;
		r = '0;
		r.status = ST_OK;
		ch = channel_index;
		case (kind)
			K_CREATE: begin
				ch = -1;
				for (int i = CHANNELS - 1; i >= 0; i--)
					if (!live[i]) ch = i;
				if (ch < 0) r.status = ST_NO_SLOT;
				else begin
					live[ch]      = 1'b1;
					owner[ch]     = requester_id;
					creator[ch]   = requester_id;
					size_cap[ch]  = (size_limit == 0 || size_limit > BODY_BYTES) ?
						4'(BODY_BYTES) : size_limit;
					depth_cap[ch] = (depth_limit == 0 || depth_limit > QUEUE_DEPTH) ?
						5'(QUEUE_DEPTH) : depth_limit[4:0];
					head[ch] = '0;
					tail[ch] = '0;
					fill[ch] = '0;
					r.slot   = ch[3:0];
				end
			end
			K_SEND: begin
				if (msg_bytes > BODY_BYTES) r.status = ST_BAD_SIZE;
				else if (!live[ch]) r.status = ST_NOT_OPEN;
				else if (fill[ch] >= depth_cap[ch] || fill[ch] >= QUEUE_DEPTH)
					r.status = ST_FULL;
				else begin
					n = (msg_bytes > size_cap[ch]) ? size_cap[ch] : msg_bytes;
					enqueue_msg(ch, requester_id, msg_type, n, payload);
				end
			end
			K_RECV: begin
				if (!live[ch]) r.status = ST_NOT_OPEN;
				else if (fill[ch] == 0) r.status = ST_EMPTY;
				else dequeue_msg(ch, r);
			end
			K_DESTROY: begin
				if (creator[ch] != requester_id) r.status = ST_NOT_CREATOR;
				else begin
					live[ch] = 1'b0;
					head[ch] = '0;
					tail[ch] = '0;
					fill[ch] = '0;
				end
			end
			K_SEND_OWN: begin
				ch = find_owned(peer_id);
				if (msg_bytes > BODY_BYTES) r.status = ST_BAD_SIZE;
				else if (ch < 0) r.status = ST_NO_ROUTE;
				else if (fill[ch] >= QUEUE_DEPTH) r.status = ST_FULL;
				else enqueue_msg(ch, requester_id, msg_type, msg_bytes, payload);
			end
			K_RECV_OWN: begin
				ch = find_owned(requester_id);
				if (ch < 0) r.status = ST_NO_ROUTE;
				else if (fill[ch] == 0) r.status = ST_EMPTY;
				else if (peer_id != 0 && m_sender[ch*QUEUE_DEPTH + head[ch]] != peer_id)
					r.status = ST_SRC_MISMATCH;
				else dequeue_msg(ch, r);
			end
			default: r.status = ST_NO_ROUTE;
		endcase
		expected_replies.push_back(r);
	endtask

	// predict on each request transfer, compare on each result
	always @(posedge clk or negedge arst_n) begin
		reply_t seen, want;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				live[i] = 0; owner[i] = 0; creator[i] = 0; size_cap[i] = 0;
				depth_cap[i] = 0; head[i] = 0; tail[i] = 0; fill[i] = 0;
			end
			expected_replies.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				seen = '{status, slot, got_type, got_bytes, got_payload, got_sender};
				if (expected_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", seen);
				end else begin
					want = expected_replies.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: status exp %0d got %0d, slot exp %0d got %0d,",
								want.status, seen.status, want.slot, seen.slot,
								" type exp %h got %h, bytes exp %0d got %0d,",
								want.rtype, seen.rtype, want.rbytes, seen.rbytes,
								" body exp %h got %h, sender exp %h got %h",
								want.rbody, seen.rbody, want.rsender, seen.rsender);
					end
				end
			end
			if (start && !busy)
				predict_mailbox_reply();
			pending = expected_replies.size();
		end
	end

endmodule

[tb/multi_channel_mailbox_queue_core_tb.sv]
module multi_channel_mailbox_queue_core_tb;
	import mcmq_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [15:0] requester_id = '0;
	logic [3:0]  channel_index = '0;
	logic [15:0] peer_id = '0;
	logic [31:0] msg_type = '0;
	logic [3:0]  msg_bytes = '0;
	logic [63:0] payload = '0;
	logic [3:0]  size_limit = '0;
	logic [7:0]  depth_limit = '0;
	logic        done;
	logic [3:0]  status;
	logic [3:0]  slot;
	logic [31:0] got_type;
	logic [3:0]  got_bytes;
	logic [63:0] got_payload;
	logic [15:0] got_sender;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;

	always #10 clk = ~clk;

	multi_channel_mailbox_queue_core i_dut (.*);

	mailbox_result_checker i_checker (.*);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (start && !busy || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// hold one request until its transfer
	task automatic issue(input logic [2:0] k, input logic [15:0] req, input logic [3:0] idx,
			input logic [15:0] peer, input logic [3:0] nb, input logic [3:0] sl,
			input logic [7:0] dl);
		kind = k; requester_id = req; channel_index = idx; peer_id = peer;
		msg_type = $urandom; msg_bytes = nb; payload = {$urandom, $urandom};
		size_limit = sl; depth_limit = dl;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		logic [15:0] ids[4];
		int burst;
		int r;
		ids = '{16'h0001, 16'hFFFF, 16'h1234, 16'h0000};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, creates, caps, errors, destroy
		issue(K_RECV_OWN, 16'h0001, 0, 0, 0, 0, 0);
		issue(K_SEND_OWN, 16'h0002, 0, 16'h0001, 4, 0, 0);
		issue(K_CREATE, 16'h0001, 0, 0, 0, 0, 0);
		issue(K_CREATE, 16'hFFFF, 0, 0, 0, 15, 255);
		issue(K_CREATE, 16'h1234, 0, 0, 0, 3, 2);
		issue(K_SEND, 16'h0005, 2, 0, 8, 0, 0);
		issue(K_SEND, 16'h0005, 2, 0, 9, 0, 0);
		issue(K_SEND, 16'h0005, 2, 0, 15, 0, 0);
		issue(K_SEND, 16'h0006, 2, 0, 0, 0, 0);
		issue(K_SEND, 16'h0006, 2, 0, 2, 0, 0);
		issue(K_SEND, 16'h0006, 9, 0, 2, 0, 0);
		issue(K_RECV, 16'h0006, 9, 0, 0, 0, 0);
		issue(K_SEND_OWN, 16'h0007, 0, 16'h1234, 8, 0, 0);
		issue(K_RECV_OWN, 16'h1234, 0, 16'h0009, 0, 0, 0);
		issue(K_RECV_OWN, 16'h1234, 0, 16'h0005, 0, 0, 0);
		issue(K_RECV_OWN, 16'h1234, 0, 0, 0, 0, 0);
		issue(K_RECV, 16'h0000, 2, 0, 0, 0, 0);
		issue(K_RECV, 16'h0000, 2, 0, 0, 0, 0);
		issue(K_DESTROY, 16'h0001, 2, 0, 0, 0, 0);
		issue(K_DESTROY, 16'h1234, 2, 0, 0, 0, 0);
		issue(K_DESTROY, 16'h1234, 2, 0, 0, 0, 0);
		issue(3'd6, 16'h0001, 0, 0, 0, 0, 0);
		issue(3'd7, 16'h0001, 0, 0, 0, 0, 0);
		for (int i = 0; i < 15; i++)
			issue(K_CREATE, 16'h0000, 0, 0, 0, 0, 0);

		// random bursts over a small set of identities
		for (int n = 0; n < 1050; ) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst; b++, n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					issue(3'($urandom_range(0, 7)), 16'($urandom), 4'($urandom),
						16'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
				else
					issue(r < 10 ? K_CREATE : r < 14 ? K_DESTROY : 3'($urandom_range(1, 5)),
						ids[$urandom_range(0, 3)], 4'($urandom_range(0, 15)),
						$urandom_range(0, 2) == 0 ? 16'h0000 : ids[$urandom_range(0, 3)],
						$urandom_range(0, 9) == 0 ? 4'($urandom_range(9, 15)) :
							4'($urandom_range(0, 8)),
						4'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
		end
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
